FILE: src/max_collinear_points_top_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef MAX_COLLINEAR_POINTS_TOP_MACROS_SVH
`define MAX_COLLINEAR_POINTS_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define MCP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MCP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/mcp_pkg.sv
package mcp_pkg;

   localparam int STORE_DEPTH_DEF = 512;
   localparam int COORD_BITS_DEF  = 16;

   // Sequencer steps, one control word each.
   typedef enum logic [3:0] {
      ST_LOAD,
      ST_INIT,
      ST_RD_I,
      ST_LAT_I,
      ST_RD_J,
      ST_LAT_J,
      ST_PAIR,
      ST_RD_R,
      ST_DIFF,
      ST_MUL,
      ST_CMP,
      ST_BEST,
      ST_NEXT_J,
      ST_NEXT_I,
      ST_DONE
   } step_type;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_INIT,
      ACT_RD_I,
      ACT_LAT_I,
      ACT_RD_J,
      ACT_LAT_J,
      ACT_PAIR,
      ACT_RD_R,
      ACT_DIFF,
      ACT_MUL,
      ACT_CMP,
      ACT_BEST,
      ACT_NEXT_J,
      ACT_NEXT_I,
      ACT_DONE
   } act_type;

   typedef enum logic [3:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NOT_FINAL,
      COND_FEW,
      COND_DUP,
      COND_R_MORE,
      COND_J_MORE,
      COND_I_MORE,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type jump;
      step_type next;
   } ucode_type;

   // The search program: when the condition holds the sequencer takes jump,
   // otherwise next.
   function automatic ucode_type ucode_rom(input step_type step);
      ucode_type w;
      case (step)
         ST_LOAD:   w = '{ACT_LOAD,   COND_NOT_FINAL, ST_LOAD,  ST_INIT};
         ST_INIT:   w = '{ACT_INIT,   COND_FEW,       ST_DONE,  ST_RD_I};
         ST_RD_I:   w = '{ACT_RD_I,   COND_NONE,      ST_LOAD,  ST_LAT_I};
         ST_LAT_I:  w = '{ACT_LAT_I,  COND_NONE,      ST_LOAD,  ST_RD_J};
         ST_RD_J:   w = '{ACT_RD_J,   COND_NONE,      ST_LOAD,  ST_LAT_J};
         ST_LAT_J:  w = '{ACT_LAT_J,  COND_NONE,      ST_LOAD,  ST_PAIR};
         ST_PAIR:   w = '{ACT_PAIR,   COND_DUP,       ST_NEXT_J, ST_RD_R};
         ST_RD_R:   w = '{ACT_RD_R,   COND_NONE,      ST_LOAD,  ST_DIFF};
         ST_DIFF:   w = '{ACT_DIFF,   COND_NONE,      ST_LOAD,  ST_MUL};
         ST_MUL:    w = '{ACT_MUL,    COND_NONE,      ST_LOAD,  ST_CMP};
         ST_CMP:    w = '{ACT_CMP,    COND_R_MORE,    ST_RD_R,  ST_BEST};
         ST_BEST:   w = '{ACT_BEST,   COND_NONE,      ST_LOAD,  ST_NEXT_J};
         ST_NEXT_J: w = '{ACT_NEXT_J, COND_J_MORE,    ST_RD_J,  ST_NEXT_I};
         ST_NEXT_I: w = '{ACT_NEXT_I, COND_I_MORE,    ST_RD_I,  ST_DONE};
         ST_DONE:   w = '{ACT_DONE,   COND_OUT_BUSY,  ST_DONE,  ST_LOAD};
         default:   w = '{ACT_NONE,   COND_ALWAYS,    ST_LOAD,  ST_LOAD};
      endcase
      return w;
   endfunction

endpackage

FILE: src/mcp_ram.sv
module mcp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/max_collinear_points_top.sv
// Loading: one point item per cycle, stored in the point RAMs.
// Search: starts after the item flagged final and yields one result item; for
//   each pair of points a 4-step read/difference/multiply/compare loop runs
//   over every stored point, and coincident pairs skip that loop. The input
//   stalls during the search.
// Reset clears the point count, the sequencer and any pending result item;
// the point RAMs are not cleared.
module max_collinear_points_top import mcp_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF,
   parameter int COORD_BITS  = COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_BITS-1:0]          req_px,
   input  logic signed [COORD_BITS-1:0]          req_py,
   input  logic                                  req_final_point,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_found,
   output logic [$clog2(STORE_DEPTH)-1:0]        rsp_first_index,
   output logic [$clog2(STORE_DEPTH)-1:0]        rsp_second_index,
   output logic [$clog2(STORE_DEPTH+1)-1:0]      rsp_point_count
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int EXT_W = CNT_W + 1;
   localparam int DIF_W = COORD_BITS + 1;
   localparam int PRD_W = 2 * DIF_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(STORE_DEPTH);

   step_type  step_ff, step_in;
   ucode_type uc;

   logic                    accept;
   logic                    take_jump;
   logic                    few;
   logic                    dup;
   logic                    out_busy;
   logic                    wr_en;
   logic [IDX_W-1:0]        rd_addr;
   logic [COORD_BITS-1:0]   x_rd, y_rd;

   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        i_ff, i_in, j_ff, j_in, r_ff, r_in;
   logic signed [COORD_BITS-1:0] xi_ff, xi_in, yi_ff, yi_in, xj_ff, xj_in, yj_ff, yj_in;
   logic signed [DIF_W-1:0] dx1_ff, dx1_in, dy1_ff, dy1_in, dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic signed [PRD_W-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in, best_cnt_ff, best_cnt_in;
   logic [IDX_W-1:0]        a_ff, a_in, b_ff, b_in, best_a_ff, best_a_in, best_b_ff, best_b_in;
   logic                    have_a_ff, have_a_in, have_b_ff, have_b_in;
   logic                    any_pair_ff, any_pair_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]        rsp_first_ff, rsp_first_in, rsp_second_ff, rsp_second_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;

   assign uc       = ucode_rom(step_ff);
   assign accept   = req_valid && !req_stall;
   assign few      = count_ff < CNT_W'(2);
   assign dup      = (xj_ff == xi_ff) && (yj_ff == yi_ff);
   assign out_busy = rsp_valid_ff && rsp_stall;
   assign wr_en    = (uc.act == ACT_LOAD) && accept && (count_ff < MAX_CNT);

   mcp_ram #(.WIDTH(COORD_BITS), .DEPTH(STORE_DEPTH)) u_x_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_px),
      .rd_addr (rd_addr),
      .rd_data (x_rd)
   );

   mcp_ram #(.WIDTH(COORD_BITS), .DEPTH(STORE_DEPTH)) u_y_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (req_py),
      .rd_addr (rd_addr),
      .rd_data (y_rd)
   );

   // Next step of the sequencer.
   always_comb begin
      case (uc.cond)
         COND_NONE:      take_jump = 1'b0;
         COND_ALWAYS:    take_jump = 1'b1;
         COND_NOT_FINAL: take_jump = !(accept && req_final_point);
         COND_FEW:       take_jump = few;
         COND_DUP:       take_jump = dup;
         COND_R_MORE:    take_jump = (EXT_W'(r_ff) + EXT_W'(1)) < EXT_W'(count_ff);
         COND_J_MORE:    take_jump = (EXT_W'(j_ff) + EXT_W'(1)) < EXT_W'(count_ff);
         COND_I_MORE:    take_jump = (EXT_W'(i_ff) + EXT_W'(2)) < EXT_W'(count_ff);
         COND_OUT_BUSY:  take_jump = out_busy;
         default:        take_jump = 1'b0;
      endcase
      step_in = take_jump ? uc.jump : uc.next;
   end

   // Outputs decoded from the control word.
   always_comb begin
      req_stall = (uc.act != ACT_LOAD);
      case (uc.act)
         ACT_RD_I: rd_addr = i_ff;
         ACT_RD_J: rd_addr = j_ff;
         default:  rd_addr = r_ff;
      endcase
   end

   // Datapath.
   always_comb begin
      count_in      = count_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      r_in          = r_ff;
      xi_in         = xi_ff;
      yi_in         = yi_ff;
      xj_in         = xj_ff;
      yj_in         = yj_ff;
      dx1_in        = dx1_ff;
      dy1_in        = dy1_ff;
      dx2_in        = dx2_ff;
      dy2_in        = dy2_ff;
      p1_in         = p1_ff;
      p2_in         = p2_ff;
      cnt_in        = cnt_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      have_a_in     = have_a_ff;
      have_b_in     = have_b_ff;
      best_cnt_in   = best_cnt_ff;
      best_a_in     = best_a_ff;
      best_b_in     = best_b_ff;
      any_pair_in   = any_pair_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      case (uc.act)
         ACT_LOAD: begin
            // A full store drops further points; the count saturates.
            if (wr_en) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         ACT_INIT: begin
            i_in        = '0;
            best_cnt_in = '0;
            best_a_in   = '0;
            best_b_in   = IDX_W'(1);
            any_pair_in = 1'b0;
         end
         ACT_LAT_I: begin
            xi_in = $signed(x_rd);
            yi_in = $signed(y_rd);
            j_in  = i_ff + IDX_W'(1);
         end
         ACT_LAT_J: begin
            xj_in = $signed(x_rd);
            yj_in = $signed(y_rd);
         end
         ACT_PAIR: begin
            dx1_in    = $signed({xj_ff[COORD_BITS-1], xj_ff})
                      - $signed({xi_ff[COORD_BITS-1], xi_ff});
            dy1_in    = $signed({yj_ff[COORD_BITS-1], yj_ff})
                      - $signed({yi_ff[COORD_BITS-1], yi_ff});
            r_in      = '0;
            cnt_in    = '0;
            have_a_in = 1'b0;
            have_b_in = 1'b0;
            if (!dup) begin
               any_pair_in = 1'b1;
            end
         end
         ACT_DIFF: begin
            dx2_in = $signed({x_rd[COORD_BITS-1], x_rd})
                   - $signed({xi_ff[COORD_BITS-1], xi_ff});
            dy2_in = $signed({y_rd[COORD_BITS-1], y_rd})
                   - $signed({yi_ff[COORD_BITS-1], yi_ff});
         end
         ACT_MUL: begin
            p1_in = dx1_ff * dy2_ff;
            p2_in = dy1_ff * dx2_ff;
         end
         ACT_CMP: begin
            // Equal cross products mean the point lies on the line.
            if (p1_ff == p2_ff) begin
               cnt_in = cnt_ff + CNT_W'(1);
               if (!have_a_ff) begin
                  a_in      = r_ff;
                  have_a_in = 1'b1;
               end else if (!have_b_ff) begin
                  b_in      = r_ff;
                  have_b_in = 1'b1;
               end
            end
            r_in = r_ff + IDX_W'(1);
         end
         ACT_BEST: begin
            if ((cnt_ff > best_cnt_ff) ||
                ((cnt_ff == best_cnt_ff) &&
                 ((a_ff < best_a_ff) || ((a_ff == best_a_ff) && (b_ff < best_b_ff))))) begin
               best_cnt_in = cnt_ff;
               best_a_in   = a_ff;
               best_b_in   = b_ff;
            end
         end
         ACT_NEXT_J: begin
            j_in = j_ff + IDX_W'(1);
         end
         ACT_NEXT_I: begin
            i_in = i_ff + IDX_W'(1);
         end
         ACT_DONE: begin
            if (!out_busy) begin
               rsp_valid_in = 1'b1;
               count_in     = '0;
               if (few) begin
                  rsp_found_in  = 1'b0;
                  rsp_first_in  = '0;
                  rsp_second_in = '0;
                  rsp_count_in  = '0;
               end else if (!any_pair_ff) begin
                  // All points coincide: every line through them holds all.
                  rsp_found_in  = 1'b1;
                  rsp_first_in  = '0;
                  rsp_second_in = IDX_W'(1);
                  rsp_count_in  = count_ff;
               end else begin
                  rsp_found_in  = 1'b1;
                  rsp_first_in  = best_a_ff;
                  rsp_second_in = best_b_ff;
                  rsp_count_in  = best_cnt_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff          <= i_in;
      j_ff          <= j_in;
      r_ff          <= r_in;
      xi_ff         <= xi_in;
      yi_ff         <= yi_in;
      xj_ff         <= xj_in;
      yj_ff         <= yj_in;
      dx1_ff        <= dx1_in;
      dy1_ff        <= dy1_in;
      dx2_ff        <= dx2_in;
      dy2_ff        <= dy2_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      cnt_ff        <= cnt_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      have_a_ff     <= have_a_in;
      have_b_ff     <= have_b_in;
      best_cnt_ff   <= best_cnt_in;
      best_a_ff     <= best_a_in;
      best_b_ff     <= best_b_in;
      any_pair_ff   <= any_pair_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_first_index  = rsp_first_ff;
   assign rsp_second_index = rsp_second_ff;
   assign rsp_point_count  = rsp_count_ff;

endmodule

FILE: src/mcp_checker.sv
`include "max_collinear_points_top_macros.svh"

module mcp_checker import mcp_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_stall,
   input logic                             req_final_point,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic                             rsp_found,
   input logic [$clog2(STORE_DEPTH)-1:0]   rsp_first_index,
   input logic [$clog2(STORE_DEPTH)-1:0]   rsp_second_index,
   input logic [$clog2(STORE_DEPTH+1)-1:0] rsp_point_count
);

   logic final_taken;
   logic rsp_empty;
   logic rsp_line;
   logic fields_zero;
   logic line_ordered;

   assign final_taken  = req_valid && !req_stall && req_final_point;
   assign rsp_empty    = rsp_valid && !rsp_found;
   assign rsp_line     = rsp_valid && rsp_found;
   assign fields_zero  = (rsp_point_count == '0) && (rsp_first_index == '0)
                         && (rsp_second_index == '0);
   assign line_ordered = (rsp_point_count >= 2) && (rsp_first_index < rsp_second_index);

   // A result item waiting on the far side stays offered.
   `MCP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "result dropped")

   // Once the final item is taken the search holds off further items.
   `MCP_ASSERT_NEXT(a_search_stalls, clock, reset, final_taken, req_stall, "no stall after final")

   // An empty result carries zero fields.
   `MCP_ASSERT_NOW(a_empty_zero, clock, reset, rsp_empty, fields_zero, "empty result not zero")

   // A found line holds at least two points, listed in rising order.
   `MCP_ASSERT_NOW(a_found_order, clock, reset, rsp_line, line_ordered, "bad count or order")

endmodule

bind max_collinear_points_top mcp_checker #(.STORE_DEPTH(STORE_DEPTH)) u_mcp_checker (.*);
